// ===== rtl/core/dfg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth field gradient package
// Shared constants, codes and types for the depth field gradient block.
// ----------------------------------------------------------------------------
package dfg_pkg;

  // Field geometry
  localparam int unsigned FIELD_SIZE = 512;
  localparam int unsigned CoordW     = $clog2(FIELD_SIZE);
  localparam int unsigned AddrW      = 2 * CoordW;
  localparam int unsigned FieldDepth = FIELD_SIZE * FIELD_SIZE;
  localparam int unsigned LastCoord  = FIELD_SIZE - 1;

  // Item field widths
  localparam int unsigned ColW   = 9;
  localparam int unsigned DepthW = 16;
  localparam int unsigned InvW   = 24;
  localparam int unsigned GradW  = 25;

  // Datapath widths
  localparam int unsigned DiffW = DepthW + 1;
  localparam int unsigned ProdW = DiffW + InvW + 1;

  // Q8.16 reciprocal: fraction bits, reset value 1.0
  localparam int unsigned FracBits = 16;
  localparam logic [InvW-1:0] InvReset = InvW'(1 << FracBits);

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } act_e;

  typedef enum logic {
    AXIS_X = 1'b0,
    AXIS_Z = 1'b1
  } axis_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_PUSH
  } seq_state_e;

  // Neighbor read order within a query
  typedef enum logic [1:0] {
    RD_XP = 2'd0,
    RD_XM = 2'd1,
    RD_ZP = 2'd2,
    RD_ZM = 2'd3
  } rd_slot_e;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [AddrW-1:0]  addr;
    logic [DepthW-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic              valid;
    axis_e             axis;
    logic              span2;
    logic [DepthW-1:0] hi;
    logic [DepthW-1:0] lo;
  } gu_req_t;

  typedef struct packed {
    logic             valid;
    axis_e            axis;
    logic [GradW-1:0] grad;
  } gu_rsp_t;

endpackage

// ===== rtl/core/dfg_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth field gradient input channel
// Valid/ready channel carrying one load or query item.
// ----------------------------------------------------------------------------
interface dfg_in_if;
  import dfg_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [ColW-1:0]   col;
  logic [ColW-1:0]   row;
  logic [DepthW-1:0] depth;

  modport source (output valid, action, col, row, depth, input ready);
  modport sink   (input valid, action, col, row, depth, output ready);

endinterface

// ===== rtl/core/dfg_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth field gradient output channel
// Valid/ready channel carrying one gradient result item.
// ----------------------------------------------------------------------------
interface dfg_out_if;
  import dfg_pkg::*;

  logic             valid;
  logic             ready;
  logic [GradW-1:0] grad_x;
  logic [GradW-1:0] grad_z;

  modport source (output valid, grad_x, grad_z, input ready);
  modport sink   (input valid, grad_x, grad_z, output ready);

endinterface

// ===== rtl/core/dfg_depth_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth field memory
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module dfg_depth_ram (
  input  logic                      clk_i,
  input  dfg_pkg::ram_req_t         req_i,
  output logic [dfg_pkg::DepthW-1:0] rdata_o
);
  import dfg_pkg::*;

  logic [DepthW-1:0] mem_q [FieldDepth];
  logic [DepthW-1:0] rdata_q;

  // Contents undefined until loaded
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end else if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dfg_grad_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient arithmetic unit
// Difference, scale by reciprocal texel size, floor shift by 16 or 17.
// ----------------------------------------------------------------------------
module dfg_grad_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [dfg_pkg::InvW-1:0] inv_i,
  input  dfg_pkg::gu_req_t         req_i,
  output dfg_pkg::gu_rsp_t         rsp_o
);
  import dfg_pkg::*;

  // Stage 1: difference
  logic                    s1_valid_q;
  axis_e                   s1_axis_q;
  logic                    s1_span2_q;
  logic signed [DiffW-1:0] diff_q;
  logic signed [DiffW-1:0] diff_d;

  // Stage 2: product
  logic                    s2_valid_q;
  axis_e                   s2_axis_q;
  logic                    s2_span2_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW-1:0] shifted;

  assign diff_d = $signed({req_i.hi[DepthW-1], req_i.hi})
                - $signed({req_i.lo[DepthW-1], req_i.lo});

  assign prod_d = diff_q * $signed({1'b0, inv_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      diff_q     <= diff_d;
      s1_axis_q  <= req_i.axis;
      s1_span2_q <= req_i.span2;
    end
    if (s1_valid_q) begin
      prod_q     <= prod_d;
      s2_axis_q  <= s1_axis_q;
      s2_span2_q <= s1_span2_q;
    end
  end

  // Arithmetic shift floors; interior span halves once more
  assign shifted = s2_span2_q ? (prod_q >>> (FracBits + 1)) : (prod_q >>> FracBits);

  assign rsp_o.valid = s2_valid_q;
  assign rsp_o.axis  = s2_axis_q;
  assign rsp_o.grad  = shifted[GradW-1:0];

endmodule

// ===== rtl/core/depth_field_gradient.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth field gradient
// Square depth field in a single-port RAM; x/z central differences, one-sided at edges.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  --------  ---  -----------------  -------------------------------------
//  in_i      in   valid / ready      action, col, row, depth
//  out_o     out  valid / ready      grad_x, grad_z
//  cfg       in   cfg_we_i (no ack)  cfg_wdata_i -> inv_texel_size
//
//  A load writes the RAM at the accept edge. A query performs four
//  neighbor reads through the one RAM port, then the sub/mul/shift
//  pipeline drains. The result then sits in the output register; a new
//  item is taken while it waits, and a query stalls in its last step only
//  if that register is still full. Reset clears control state and sets
//  inv_texel_size to 1.0; the depth RAM is not cleared.
// ----------------------------------------------------------------------------
module depth_field_gradient (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  dfg_in_if.sink                   in_i,
  dfg_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic [dfg_pkg::InvW-1:0] cfg_wdata_i
);
  import dfg_pkg::*;

  // Configuration
  logic [InvW-1:0] inv_q;

  // Sequencer
  seq_state_e   state_q, state_d;
  rd_slot_e     slot_q, slot_d;

  // Query coordinates, captured at accept
  logic [CoordW-1:0] xc, zc, xm, xp, zm, zp;
  logic [CoordW-1:0] x_q, z_q, xm_q, xp_q, zm_q, zp_q;
  logic              span2_x_q, span2_z_q;

  // Read return tracking
  logic              rvalid_q;
  rd_slot_e          rtag_q;
  logic [DepthW-1:0] rdata;
  logic [DepthW-1:0] hi_q;

  // Result staging and output register
  logic [GradW-1:0] gx_q, gz_q;
  logic             out_valid_q, out_valid_d;
  logic [GradW-1:0] out_gx_q, out_gz_q;
  logic             out_load;

  logic       accept;
  logic       load_in_range;
  ram_req_t   ram_req;
  gu_req_t    gu_req;
  gu_rsp_t    gu_rsp;

  assign accept = in_i.valid && in_i.ready;

  // Loads outside the field are dropped; queries saturate to the last texel
  assign load_in_range = ({1'b0, in_i.col} < (ColW + 1)'(FIELD_SIZE))
                      && ({1'b0, in_i.row} < (ColW + 1)'(FIELD_SIZE));

  assign xc = ({1'b0, in_i.col} > (ColW + 1)'(LastCoord)) ? CoordW'(LastCoord)
                                                          : CoordW'(in_i.col);
  assign zc = ({1'b0, in_i.row} > (ColW + 1)'(LastCoord)) ? CoordW'(LastCoord)
                                                          : CoordW'(in_i.row);
  // Clamped neighbors
  assign xm = (xc == '0) ? xc : xc - 1'b1;
  assign xp = (xc == CoordW'(LastCoord)) ? xc : xc + 1'b1;
  assign zm = (zc == '0) ? zc : zc - 1'b1;
  assign zp = (zc == CoordW'(LastCoord)) ? zc : zc + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= InvReset;
    end else if (cfg_we_i) begin
      inv_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (in_i.action == ACT_QUERY)) begin
      x_q       <= xc;
      z_q       <= zc;
      xm_q      <= xm;
      xp_q      <= xp;
      zm_q      <= zm;
      zp_q      <= zp;
      span2_x_q <= (xp != xm) && (xp - xm != CoordW'(1));
      span2_z_q <= (zp != zm) && (zp - zm != CoordW'(1));
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.action == ACT_QUERY)) begin
          state_d = ST_READ;
          slot_d  = RD_XP;
        end
      end
      ST_READ: begin
        slot_d = rd_slot_e'(slot_q + 2'd1);
        if (slot_q == RD_ZM) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (gu_rsp.valid && (gu_rsp.axis == AXIS_Z)) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_i.ready    = 1'b0;
    out_load      = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.re    = 1'b0;
    ram_req.addr  = {in_i.row[CoordW-1:0], in_i.col[CoordW-1:0]};
    ram_req.wdata = in_i.depth;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        ram_req.we = in_i.valid && (in_i.action == ACT_LOAD) && load_in_range;
      end
      ST_READ: begin
        ram_req.re = 1'b1;
        case (slot_q)
          RD_XP:   ram_req.addr = {z_q, xp_q};
          RD_XM:   ram_req.addr = {z_q, xm_q};
          RD_ZP:   ram_req.addr = {zp_q, x_q};
          RD_ZM:   ram_req.addr = {zm_q, x_q};
          default: ram_req.addr = {z_q, x_q};
        endcase
      end
      ST_PUSH: begin
        out_load = !out_valid_q || out_o.ready;
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= RD_XP;
      rvalid_q    <= 1'b0;
      rtag_q      <= RD_XP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      rvalid_q    <= ram_req.re;
      rtag_q      <= slot_q;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  dfg_depth_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  // Even slots return the plus neighbor, odd slots the minus one
  always_ff @(posedge clk_i) begin
    if (rvalid_q && !rtag_q[0]) begin
      hi_q <= rdata;
    end
  end

  assign gu_req.valid = rvalid_q && rtag_q[0];
  assign gu_req.axis  = rtag_q[1] ? AXIS_Z : AXIS_X;
  assign gu_req.span2 = rtag_q[1] ? span2_z_q : span2_x_q;
  assign gu_req.hi    = hi_q;
  assign gu_req.lo    = rdata;

  dfg_grad_unit u_grad (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .inv_i  (inv_q),
    .req_i  (gu_req),
    .rsp_o  (gu_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (gu_rsp.valid && (gu_rsp.axis == AXIS_X)) begin
      gx_q <= gu_rsp.grad;
    end
    if (gu_rsp.valid && (gu_rsp.axis == AXIS_Z)) begin
      gz_q <= gu_rsp.grad;
    end
    if (out_load) begin
      out_gx_q <= gx_q;
      out_gz_q <= gz_q;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.grad_x = out_gx_q;
  assign out_o.grad_z = out_gz_q;

`ifndef SYNTH
  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> (state_q == ST_IDLE))
    else $error("depth RAM written outside idle");

  a_rsp_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gu_rsp.valid |-> (state_q == ST_READ || state_q == ST_DRAIN))
    else $error("gradient returned outside a query");

  a_push_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH) |-> (!gu_rsp.valid && !rvalid_q && !gu_req.valid))
    else $error("pipeline not empty at result push");

  a_read_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> $past(state_q == ST_READ))
    else $error("read data without a read");

  a_four_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ && slot_q == RD_ZM) |=> (state_q == ST_DRAIN))
    else $error("read phase did not end after four reads");
`endif

endmodule
